@@ hw/rtl/swm_pkg.sv @@
// Shared constants and types for the sliding window median filter.
`timescale 1ns / 1ps

package swm_pkg;

  localparam int unsigned SAMPLE_BITS = 16;
  localparam int unsigned MAX_WINDOW  = 16;
  localparam int unsigned AGE_BITS    = $clog2(MAX_WINDOW);
  localparam int unsigned IDX_BITS    = $clog2(MAX_WINDOW);
  localparam int unsigned LEN_BITS    = 5;

  localparam logic [LEN_BITS-1:0] LEN_RESET = LEN_BITS'(MAX_WINDOW);
  localparam logic [LEN_BITS-1:0] LEN_MIN   = LEN_BITS'(1);

  // One entry of the sorted window.
  typedef struct packed {
    logic                   valid;
    logic [SAMPLE_BITS-1:0] value;
    logic [AGE_BITS-1:0]    age;
  } entry_t;

  localparam entry_t ENTRY_EMPTY = '{valid: 1'b0, value: '0, age: '0};

endpackage

@@ hw/rtl/sliding_window_median.sv @@
// Top level of the sliding window median filter: cell chain, length register, output word.
//
// Usage:
//   Input channel s_axis_*: one signed 16-bit sample per word.
//   Output channel m_axis_*: one word per input word, the median in tdata and
//   a ready flag in tuser that is 1 once the window holds window_length samples;
//   while the flag is 0 the median reads 0.
//   Configuration channel cfg_*: a write sets window_length (0 acts as 1, above
//   16 acts as 16) and empties the window. It is always ready; write it only
//   while no word is in flight.
// Timing:
//   A sample is taken into a row of 16 cells, which evict the oldest entry and
//   insert the new one in sorted place in the same cycle. The result appears in
//   the output register in the cycle after the sample is accepted, and one sample
//   can be accepted every cycle while the receiver does not stall.
//   When the receiver stalls, the output register holds its word and the input
//   is taken only when the output register is empty or being emptied.
// Reset:
//   Empties the window, sets window_length to 16 and empties the output register.
`timescale 1ns / 1ps

module sliding_window_median (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Input word, tdata: sample[15:0]
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [swm_pkg::SAMPLE_BITS-1:0] s_axis_tdata,
  // Output word, tdata: median[15:0]; tuser: ready_res[0]
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [swm_pkg::SAMPLE_BITS-1:0] m_axis_tdata,
  output logic                            m_axis_tuser,
  // Window length write
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [swm_pkg::LEN_BITS-1:0]    cfg_data_i
);
  import swm_pkg::*;

  logic                   step;
  logic                   clear;
  logic [LEN_BITS-1:0]    len_q;
  logic [LEN_BITS-1:0]    len_eff;
  logic [AGE_BITS-1:0]    age_last;
  logic [IDX_BITS-1:0]    mid_idx;
  logic                   full;
  logic                   out_valid_q;
  logic [SAMPLE_BITS-1:0] out_median_q, out_median_d;
  logic                   out_ready_q,  out_ready_d;

  entry_t                 cur   [MAX_WINDOW];
  entry_t                 post  [MAX_WINDOW];
  entry_t                 nxt   [MAX_WINDOW];
  entry_t                 upper [MAX_WINDOW];
  entry_t                 prev  [MAX_WINDOW];
  logic [MAX_WINDOW-1:0]  gt;
  logic [MAX_WINDOW-1:0]  prev_gt;
  logic [MAX_WINDOW-1:0]  shift_in;
  logic [MAX_WINDOW-1:0]  shift_out;

  // Handshakes.
  assign cfg_ready_o   = 1'b1;
  assign clear         = cfg_valid_i;
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign step          = s_axis_tvalid && s_axis_tready;

  // Window length register, clamped to the supported range on write.
  always_comb begin
    priority if (cfg_data_i == '0) begin
      len_eff = LEN_MIN;
    end else if (cfg_data_i > LEN_RESET) begin
      len_eff = LEN_RESET;
    end else begin
      len_eff = cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= LEN_RESET;
    end else if (clear) begin
      len_q <= len_eff;
    end
  end

  assign age_last = AGE_BITS'(len_q - LEN_MIN);
  assign mid_idx  = IDX_BITS'(len_q >> 1);
  assign full     = cur[age_last].valid;

  // Neighbour wiring of the cell row.
  always_comb begin
    for (int i = 0; i < MAX_WINDOW; i++) begin
      if (i == MAX_WINDOW - 1) begin
        upper[i] = ENTRY_EMPTY;
      end else begin
        upper[i] = cur[i + 1];
      end
      if (i == 0) begin
        shift_in[i] = 1'b0;
        prev[i]     = '{valid: 1'b1, value: '0, age: '0};
        prev_gt[i]  = 1'b0;
      end else begin
        shift_in[i] = shift_out[i - 1];
        prev[i]     = post[i - 1];
        prev_gt[i]  = gt[i - 1];
      end
    end
  end

  for (genvar g = 0; g < MAX_WINDOW; g++) begin : g_cell
    swm_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .step_i      (step),
      .clear_i     (clear),
      .full_i      (full),
      .age_last_i  (age_last),
      .sample_i    (s_axis_tdata),
      .upper_i     (upper[g]),
      .shift_in_i  (shift_in[g]),
      .prev_post_i (prev[g]),
      .prev_gt_i   (prev_gt[g]),
      .entry_o     (cur[g]),
      .shift_out_o (shift_out[g]),
      .post_o      (post[g]),
      .gt_o        (gt[g]),
      .next_o      (nxt[g])
    );
  end

  // Result: the middle entry of the updated window once it is full.
  always_comb begin
    out_ready_d  = nxt[age_last].valid;
    out_median_d = out_ready_d ? nxt[mid_idx].value : '0;
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_median_q <= out_median_d;
      out_ready_q  <= out_ready_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_median_q;
  assign m_axis_tuser  = out_ready_q;

endmodule

@@ hw/rtl/swm_cell.sv @@
// One cell of the sorted chain: holds one window entry and updates it from its neighbours.
`timescale 1ns / 1ps

module swm_cell (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            step_i,
  input  logic                            clear_i,
  input  logic                            full_i,
  input  logic [swm_pkg::AGE_BITS-1:0]    age_last_i,
  input  logic [swm_pkg::SAMPLE_BITS-1:0] sample_i,
  input  swm_pkg::entry_t                 upper_i,
  input  logic                            shift_in_i,
  input  swm_pkg::entry_t                 prev_post_i,
  input  logic                            prev_gt_i,
  output swm_pkg::entry_t                 entry_o,
  output logic                            shift_out_o,
  output swm_pkg::entry_t                 post_o,
  output logic                            gt_o,
  output swm_pkg::entry_t                 next_o
);
  import swm_pkg::*;

  entry_t entry_q, entry_d;
  logic   evict;
  logic   insert;

  // The oldest entry leaves when the window is full; every cell above it moves down.
  assign evict       = full_i && entry_q.valid && (entry_q.age == age_last_i);
  assign shift_out_o = shift_in_i || evict;
  assign post_o      = shift_out_o ? upper_i : entry_q;

  // The new sample goes in at the first cell holding a greater value or no value.
  assign gt_o   = post_o.valid && ($signed(post_o.value) > $signed(sample_i));
  assign insert = prev_post_i.valid && !prev_gt_i && (gt_o || !post_o.valid);

  always_comb begin
    entry_d = ENTRY_EMPTY;
    priority if (prev_gt_i) begin
      entry_d.valid = 1'b1;
      entry_d.value = prev_post_i.value;
      entry_d.age   = prev_post_i.age + AGE_BITS'(1);
    end else if (insert) begin
      entry_d.valid = 1'b1;
      entry_d.value = sample_i;
      entry_d.age   = '0;
    end else if (post_o.valid) begin
      entry_d.valid = 1'b1;
      entry_d.value = post_o.value;
      entry_d.age   = post_o.age + AGE_BITS'(1);
    end else begin
      entry_d = ENTRY_EMPTY;
    end
  end

  assign next_o  = entry_d;
  assign entry_o = entry_q;

  // Entry register: cleared by reset and by a length write.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q <= ENTRY_EMPTY;
    end else if (clear_i) begin
      entry_q <= ENTRY_EMPTY;
    end else if (step_i) begin
      entry_q <= entry_d;
    end
  end

endmodule

@@ tb/tb.sv @@
// Self-checking testbench for the sliding window median filter.
`timescale 1ns / 1ps

module tb;

  import swm_pkg::*;

  localparam int unsigned SB         = SAMPLE_BITS;
  localparam int unsigned IDLE_LIMIT = 4000;

  typedef enum int unsigned {
    STALL_NONE,
    STALL_RANDOM,
    STALL_RUNS
  } stall_mode_e;

  // One expected output word.
  typedef struct {
    logic [SB-1:0] median;
    logic          ready;
  } median_word_t;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [SB-1:0]       s_axis_tdata  = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [SB-1:0]       m_axis_tdata;
  logic                m_axis_tuser;
  logic                cfg_valid_i   = 1'b0;
  logic                cfg_ready_o;
  logic [LEN_BITS-1:0] cfg_data_i    = '0;

  // Model of the window: values ascending, ages, fill level and length register.
  logic signed [SB-1:0] win_val [MAX_WINDOW];
  logic [AGE_BITS-1:0]  win_age [MAX_WINDOW];
  int unsigned          win_fill;
  logic [LEN_BITS-1:0]  win_len;

  median_word_t median_q [$];
  int unsigned  fail_count  = 0;
  int unsigned  idle_cycles = 0;
  bit           gaps_on     = 1'b0;
  int unsigned  burst_left  = 0;
  stall_mode_e  stall_mode  = STALL_NONE;
  int unsigned  stall_run   = 0;
  bit           ready_phase = 1'b1;

  sliding_window_median uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  // Clock, 8 ns period.
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Empties the model window, as a reset or a length write does.
  function automatic void clear_window();
    int unsigned i;
    for (i = 0; i < MAX_WINDOW; i++) begin
      win_val[i] = '0;
      win_age[i] = '0;
    end
    win_fill = 0;
  endfunction

  // Evicts the oldest sample once full, inserts the new one in sorted place and
  // returns the median word that the block should emit for it.
  function automatic median_word_t update_window(input logic signed [SB-1:0] s);
    int unsigned  len, pos, i;
    median_word_t w;
    if (win_len == 0) len = 1;
    else if (win_len > MAX_WINDOW) len = MAX_WINDOW;
    else len = win_len;
    if (win_fill > len) win_fill = len;
    if (win_fill == len && win_fill > 0) begin
      pos = win_fill - 1;
      for (i = 0; i < win_fill; i++) begin
        if (win_age[i] == len - 1) begin
          pos = i;
          break;
        end
      end
      for (i = pos; i + 1 < win_fill; i++) begin
        win_val[i] = win_val[i+1];
        win_age[i] = win_age[i+1];
      end
      win_fill--;
      win_val[win_fill] = '0;
      win_age[win_fill] = '0;
    end
    for (i = 0; i < win_fill; i++) win_age[i]++;
    // Equal values stay oldest first, so the newcomer goes after them.
    pos = win_fill;
    for (i = 0; i < win_fill; i++) begin
      if (win_val[i] > s) begin
        pos = i;
        break;
      end
    end
    for (i = win_fill; i > pos; i--) begin
      win_val[i] = win_val[i-1];
      win_age[i] = win_age[i-1];
    end
    win_val[pos] = s;
    win_age[pos] = '0;
    win_fill++;
    if (win_fill == len) begin
      w.median = win_val[len/2];
      w.ready  = 1'b1;
    end else begin
      w.median = '0;
      w.ready  = 1'b0;
    end
    return w;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    fail_count++;
  endtask

  // Sends one sample word and records the expected median word once it is taken.
  task automatic push_sample(input logic [SB-1:0] s);
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= s;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    median_q.push_back(update_window(s));
    // Bursts of random length separated by random gaps.
    if (gaps_on) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 12);
        @(negedge clk_i);
        s_axis_tvalid <= 1'b0;
        repeat ($urandom_range(0, 8)) @(negedge clk_i);
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic idle_sender();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
  endtask

  task automatic wait_results_drained();
    while (median_q.size() != 0) @(posedge clk_i);
  endtask

  // Length writes happen only with the block idle and every result collected.
  task automatic write_window_length(input logic [LEN_BITS-1:0] v);
    idle_sender();
    wait_results_drained();
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    win_len = v;
    clear_window();
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Mix of full-range values, a narrow band full of duplicates, the extremes and small clusters at 0x8000 and 0x4000.
  function automatic logic [SB-1:0] pick_sample();
    logic [SB-1:0] s;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: s = SB'($urandom);
      6, 7:             s = SB'($urandom_range(0, 6)) - SB'(3);
      8: begin
        case ($urandom_range(0, 3))
          0:       s = {1'b1, {(SB-1){1'b0}}};
          1:       s = {1'b0, {(SB-1){1'b1}}};
          2:       s = '0;
          default: s = '1;
        endcase
      end
      default: s = {$urandom_range(0, 1) ? 2'b10 : 2'b01, (SB-2)'($urandom_range(0, 3))};
    endcase
    return s;
  endfunction

  task automatic run_random_phase(input logic [LEN_BITS-1:0] len, input int unsigned n);
    int unsigned k;
    write_window_length(len);
    gaps_on    = $urandom_range(0, 3) != 0;
    stall_mode = stall_mode_e'($urandom_range(0, 2));
    for (k = 0; k < n; k++) push_sample(pick_sample());
  endtask

  // Reset length of 16: extremes, duplicates, first ready word and one eviction.
  task automatic test_reset_window();
    logic [SB-1:0] vals [17];
    int unsigned   k;
    vals = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 16'h0001, 16'h8000, 16'h7FFF,
             16'h5555, 16'hAAAA, 16'h0000, 16'h0000, 16'hFFFF, 16'h1234, 16'h8001,
             16'h7FFE, 16'h0000, 16'h7FFF};
    gaps_on    = 1'b0;
    stall_mode = STALL_NONE;
    for (k = 0; k < 17; k++) push_sample(vals[k]);
  endtask

  // A length of zero acts as a window of one.
  task automatic test_zero_length();
    write_window_length('0);
    push_sample(16'h7FFF);
    push_sample(16'h8000);
  endtask

  // Even window: the median is the upper of the two middle samples.
  task automatic test_even_length();
    write_window_length(LEN_BITS'(2));
    gaps_on    = 1'b1;
    stall_mode = STALL_RUNS;
    push_sample(16'h0005);
    push_sample(16'hFFFB);
    push_sample(16'h0003);
  endtask

  // Many lengths, the oversized ones and the extremes among them.
  task automatic test_random_lengths();
    logic [LEN_BITS-1:0] lens [12];
    int unsigned         k;
    lens = '{5'd1, 5'd16, 5'd31, 5'd0, 5'd2, 5'd3, 5'd8, 5'd15, 5'd17, 5'd24,
             LEN_BITS'($urandom_range(1, 16)), LEN_BITS'($urandom)};
    for (k = 0; k < 12; k++) run_random_phase(lens[k], 90);
  endtask

  // The sender stops part way until every result is back, then carries on.
  task automatic test_sender_pause();
    int unsigned k;
    run_random_phase(LEN_BITS'($urandom_range(4, 16)), 30);
    idle_sender();
    wait_results_drained();
    for (k = 0; k < 30; k++) push_sample(pick_sample());
  endtask

  // Receiver back-pressure: none, random, or runs of random length.
  always @(negedge clk_i) begin
    case (stall_mode)
      STALL_NONE:   m_axis_tready <= 1'b1;
      STALL_RANDOM: m_axis_tready <= ($urandom_range(0, 3) != 0);
      default: begin
        if (stall_run == 0) begin
          ready_phase = !ready_phase;
          stall_run   = ready_phase ? $urandom_range(1, 9) : $urandom_range(1, 6);
        end else begin
          stall_run--;
        end
        m_axis_tready <= ready_phase;
      end
    endcase
  end

  // Each output word against the oldest expectation.
  always @(posedge clk_i) begin
    median_word_t w;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (median_q.size() == 0) begin
        report_mismatch($sformatf("unexpected word median=%h ready=%b",
                                  m_axis_tdata, m_axis_tuser));
      end else begin
        w = median_q.pop_front();
        if (m_axis_tdata !== w.median)
          report_mismatch($sformatf("median %h, expected %h", m_axis_tdata, w.median));
        if (m_axis_tuser !== w.ready)
          report_mismatch($sformatf("ready %b, expected %b", m_axis_tuser, w.ready));
      end
    end
  end

  // Watchdog on cycles in which no channel moves a word.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
          $display("== FAIL ==");
          $finish;
        end
      end
    end
  end

  // Test sequence.
  initial begin
    win_len = LEN_RESET;
    clear_window();
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_window();
    test_zero_length();
    test_even_length();
    test_random_lengths();
    test_sender_pause();

    idle_sender();
    wait_results_drained();
    repeat (4) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
